// File: rtl/dsa_pkg.sv
// Shared types and constants for the scaled-decimal arithmetic unit.
// Holds the operation codes, the register indexes and the classified command record.
// No dependencies.
`default_nettype none
package dsa_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_RESULT = 2'd2;

  localparam int unsigned MaxScale = 18;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    op_e         op;
    logic [63:0] l_mag;
    logic        l_neg;
    logic [63:0] r_mag;
    logic        r_neg;
    logic        r_zero;
    logic [4:0]  ls;
    logic [4:0]  rs;
    logic [4:0]  ts;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/dsa_front.sv
// Front end: scale registers on the APB port and classification of incoming items.
// Depends on dsa_pkg.
`default_nettype none
module dsa_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire  [3:0]       paddr,
  input  wire  [31:0]      pwdata,
  output logic [31:0]      prdata,
  input  wire  [1:0]       op_i,
  input  wire  [63:0]      left_value_i,
  input  wire  [63:0]      right_value_i,
  output dsa_pkg::cmd_t    cmd_o
);
  import dsa_pkg::*;

  localparam int Sh = 64 - VALUE_WIDTH;

  logic [4:0] left_scale_q, right_scale_q, result_scale_q;
  logic       wr_en;
  logic [63:0] lt, rt, lv, rv;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_scale_q   <= '0;
      right_scale_q  <= '0;
      result_scale_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LEFT:   left_scale_q   <= pwdata[4:0];
        REG_RIGHT:  right_scale_q  <= pwdata[4:0];
        REG_RESULT: result_scale_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEFT:   prdata = {27'd0, left_scale_q};
      REG_RIGHT:  prdata = {27'd0, right_scale_q};
      REG_RESULT: prdata = {27'd0, result_scale_q};
      default:    prdata = '0;
    endcase
  end

  function automatic logic [4:0] eff(input logic [4:0] s);
    return (s > 5'(MaxScale)) ? 5'(MaxScale) : s;
  endfunction

  // Operands are the low VALUE_WIDTH bits of each field, sign-extended.
  assign lt = left_value_i << Sh;
  assign rt = right_value_i << Sh;
  assign lv = 64'($signed(lt) >>> Sh);
  assign rv = 64'($signed(rt) >>> Sh);

  always_comb begin
    cmd_o.op     = op_e'(op_i);
    cmd_o.l_neg  = lv[63];
    cmd_o.l_mag  = lv[63] ? (64'd0 - lv) : lv;
    cmd_o.r_neg  = rv[63];
    cmd_o.r_mag  = rv[63] ? (64'd0 - rv) : rv;
    cmd_o.r_zero = (rv == 64'd0);
    cmd_o.ls     = eff(left_scale_q);
    cmd_o.rs     = eff(right_scale_q);
    cmd_o.ts     = eff(result_scale_q);
  end

endmodule
`default_nettype wire

// File: rtl/dsa_queue.sv
// Short queue of classified commands between the front and back ends.
// Depends on dsa_pkg.
`default_nettype none
module dsa_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  dsa_pkg::cmd_t    push_data_i,
  input  wire              pop_i,
  output dsa_pkg::cmd_t    pop_data_o,
  output logic             empty_o,
  output logic             full_o
);
  import dsa_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == (PtrW+1)'(QueueDepth));
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/dsa_back.sv
// Back end: sequencer that carries out one command with a shared 128-bit datapath
// (times-ten step, 32x32 partial products, chunked divide-by-ten, one-bit-per-cycle
// divider). Depends on dsa_pkg.
`default_nettype none
module dsa_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cmd_valid_i,
  input  dsa_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [63:0]      result_value_o
);
  import dsa_pkg::*;

  localparam int Sh = 64 - VALUE_WIDTH;
  localparam logic [63:0] MaxPos = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MULP = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_TEN  = 3'd6;

  logic [2:0]   state_q, state_d;
  logic         phase_q, phase_d;
  cmd_t         cmd_q, cmd_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  dvs_q, dvs_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [5:0]   up_q, up_d, dn_q, dn_d;
  logic [63:0]  part_q, part_d;
  logic         qneg_q, qneg_d;
  logic         eneg_q, eneg_d;
  logic [63:0]  res_q, res_d;
  logic         vld_q, vld_d;

  function automatic logic [63:0] wrap_w(input logic [63:0] x);
    logic [63:0] t;
    t = x << Sh;
    return 64'($signed(t) >>> Sh);
  endfunction

  logic signed [6:0] e_s;
  logic [5:0]   raw;
  logic [4:0]   from_s;
  logic [63:0]  from_mag;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  rem2;
  logic         ge;
  logic [63:0]  signed_low;
  logic [127:0] v128, m128;
  logic [19:0]  tv, tq10, tdiff;
  logic [39:0]  tprod;
  logic [15:0]  tq;

  assign e_s = $signed({2'b00, cmd_q.ts}) + $signed({2'b00, cmd_q.rs})
             - $signed({2'b00, cmd_q.ls});
  assign raw      = {1'b0, cmd_q.ls} + {1'b0, cmd_q.rs};
  assign from_s   = phase_q ? cmd_q.rs : cmd_q.ls;
  assign from_mag = phase_q ? cmd_q.r_mag : cmd_q.l_mag;
  assign ah       = cnt_q[1] ? cmd_q.l_mag[63:32] : cmd_q.l_mag[31:0];
  assign bh       = cnt_q[0] ? cmd_q.r_mag[63:32] : cmd_q.r_mag[31:0];
  assign pp       = ah * bh;
  assign rem2     = {rem_q, acc_q[127]};
  assign ge       = (rem2 >= {1'b0, dvs_q});
  assign v128     = cmd_q.l_neg ? (128'd0 - acc_q) : acc_q;
  assign m128     = v128[127] ? (128'd0 - v128) : v128;

  // One sixteen-bit digit of long division by ten: the reciprocal 0xCCCCD / 2^23 is
  // exact for every value below 2^22, and the partial value stays below 10 * 2^16.
  assign tv    = {rem_q[3:0], acc_q[127:112]};
  assign tprod = {20'd0, tv} * 40'hCCCCD;
  assign tq    = tprod[38:23];
  assign tq10  = {1'b0, tq, 3'b000} + {3'b000, tq, 1'b0};
  assign tdiff = tv - tq10;

  always_comb begin
    case (cnt_q[1:0])
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    // Sign of the current operand, product or quotient applied to the low word.
    case (cmd_q.op)
      OP_ADD, OP_SUB: begin
        signed_low = (phase_q ? cmd_q.r_neg : cmd_q.l_neg) ? (64'd0 - acc_q[63:0])
                                                            : acc_q[63:0];
      end
      OP_MUL:  signed_low = (cmd_q.l_neg ^ cmd_q.r_neg) ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
      default: signed_low = qneg_q ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    up_d    = up_q;
    dn_d    = dn_q;
    part_d  = part_q;
    qneg_d  = qneg_q;
    eneg_d  = eneg_q;
    res_d   = res_q;
    vld_d   = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          phase_d = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        case (cmd_q.op)
          OP_ADD, OP_SUB: begin
            acc_d = {64'd0, from_mag};
            if (cmd_q.ts >= from_s) begin
              up_d = {1'b0, cmd_q.ts - from_s};
              dn_d = '0;
            end else begin
              up_d = '0;
              dn_d = {1'b0, from_s - cmd_q.ts};
            end
            state_d = S_UP;
          end
          OP_MUL: begin
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_MULP;
          end
          default: begin
            if (cmd_q.r_zero) begin
              res_d   = wrap_w(MaxPos);
              vld_d   = 1'b1;
              state_d = S_IDLE;
            end else begin
              acc_d   = {64'd0, cmd_q.l_mag};
              eneg_d  = e_s[6];
              up_d    = e_s[6] ? 6'd0 : e_s[5:0];
              dn_d    = e_s[6] ? 6'(-e_s) : 6'd0;
              state_d = S_UP;
            end
          end
        endcase
      end
      S_MULP: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'b11) begin
          if ({1'b0, cmd_q.ts} >= raw) begin
            up_d = {1'b0, cmd_q.ts} - raw;
            dn_d = '0;
          end else begin
            up_d = '0;
            dn_d = raw - {1'b0, cmd_q.ts};
          end
          state_d = S_UP;
        end
      end
      S_UP: begin
        if (up_q != '0) begin
          acc_d = (acc_q << 3) + (acc_q << 1);
          up_d  = up_q - 6'd1;
        end else if (dn_q != '0) begin
          // Scale-down removes one digit per pass of eight sixteen-bit steps.
          dn_d    = dn_q - 6'd1;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_TEN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TEN: begin
        acc_d = {acc_q[111:0], tq};
        rem_d = {60'd0, tdiff[3:0]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[2:0] == 3'd7) begin
          state_d = S_UP;
        end
      end
      S_DIV: begin
        rem_d = ge ? 64'(rem2 - {1'b0, dvs_q}) : rem2[63:0];
        acc_d = {acc_q[126:0], ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          state_d = S_UP;
        end
      end
      S_FIN: begin
        case (cmd_q.op)
          OP_ADD, OP_SUB: begin
            if (!phase_q) begin
              part_d  = signed_low;
              phase_d = 1'b1;
              state_d = S_LOAD;
            end else begin
              res_d   = wrap_w((cmd_q.op == OP_ADD) ? (part_q + signed_low)
                                                    : (part_q - signed_low));
              vld_d   = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_MUL: begin
            res_d   = wrap_w(signed_low);
            vld_d   = 1'b1;
            state_d = S_IDLE;
          end
          default: begin
            if (!phase_q) begin
              // When scaled up, the prescaled numerator is read back as a signed 128-bit value.
              if (eneg_q) begin
                qneg_d = cmd_q.l_neg ^ cmd_q.r_neg;
              end else begin
                qneg_d = v128[127] ^ cmd_q.r_neg;
                acc_d  = m128;
              end
              dvs_d   = cmd_q.r_mag;
              rem_d   = '0;
              cnt_d   = '0;
              phase_d = 1'b1;
              state_d = S_DIV;
            end else begin
              res_d   = wrap_w(signed_low);
              vld_d   = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    cmd_q   <= cmd_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
    up_q    <= up_d;
    dn_q    <= dn_d;
    part_q  <= part_d;
    qneg_q  <= qneg_d;
    eneg_q  <= eneg_d;
    res_q   <= res_d;
  end

  assign result_valid_o = vld_q;
  assign result_value_o = res_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE))
    else $error("command taken while sequencer busy");
  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dvs_q != 64'd0))
    else $error("divider running with zero divisor");
  a_ten_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEN) |-> (rem_q < 64'd10))
    else $error("divide-by-ten remainder out of range");
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d |-> (state_q == S_FIN || state_q == S_LOAD))
    else $error("result produced outside a finishing step");
`endif

endmodule
`default_nettype wire

// File: rtl/decimal_scaled_arithmetic.sv
// Top level of the scaled-decimal arithmetic unit: front end, command queue, back end.
// Depends on dsa_pkg, dsa_front, dsa_queue and dsa_back.
//
//  Channel   Direction  Handshake                    Payload
//  config    in/out     psel/penable/pwrite/pready   paddr, pwdata, prdata
//  command   in         start / busy                 op_i, left_value_i, right_value_i
//  result    out        result_valid_o (strobe)      result_value_o
//
// Items enter at one per cycle until the four-entry queue fills; busy marks a full queue.
// The back-end sequencer runs one item at a time; its divider forms one quotient bit per
// cycle and a divide by zero ends in the load step. Scaling takes one times-ten step per
// digit up and one digit-serial divide-by-ten pass per digit down, for each operand,
// product or numerator. The strobe is registered behind the finishing step.
// Reset clears the scales, the queue and the sequencer; results cannot be stalled.
`default_nettype none
module decimal_scaled_arithmetic #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  op_i,
  input  wire  [63:0] left_value_i,
  input  wire  [63:0] right_value_i,
  output logic        result_valid_o,
  output logic [63:0] result_value_o
);
  import dsa_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic empty, full, pop, push;

  assign pready = 1'b1;
  assign busy   = full;
  assign push   = start && !full;

  dsa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .op_i, .left_value_i, .right_value_i, .cmd_o(cmd_in)
  );

  dsa_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(cmd_in), .pop_i(pop),
    .pop_data_o(cmd_out), .empty_o(empty), .full_o(full)
  );

  dsa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(!empty), .cmd_i(cmd_out), .pop_o(pop),
    .result_valid_o, .result_value_o
  );

endmodule
`default_nettype wire
